[sv/rrbs_pkg.sv]
// ----------------------------------------------------------------------------
// rrbs_pkg: shared types and constants for the round-robin backend selector
// Command and status codes, scan modes and the control/status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rrbs_pkg;

  // Default table depth and reset value of the re-enable timeout
  localparam int          MAX_ENTRIES_DEF = 16;
  localparam logic [15:0] REEN_RESET      = 16'd60;

  // Input commands
  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_DIS  = 2'd1,
    CMD_SEL  = 2'd2,
    CMD_TICK = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONE      = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // What a table scan does to each entry
  typedef enum logic [1:0] {
    SCAN_DIS  = 2'd0,
    SCAN_REEN = 2'd1,
    SCAN_SEL  = 2'd2
  } scan_mode_t;

  // Controller to datapath
  typedef struct packed {
    logic       accept;
    logic       add;
    logic       tick;
    logic       scan_start;
    scan_mode_t scan_mode;
    logic       mod_start;
    logic       mod_step;
    logic       load_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic en_zero;
    logic cnt_zero;
    logic scan_done;
    logic mod_done;
  } dp_stat_t;

endpackage

`default_nettype wire

[sv/rrbs_ctrl.sv]
// ----------------------------------------------------------------------------
// rrbs_ctrl: sequencing controller
// Takes one word at a time, steps the datapath through add, tick, disable
// scan, re-enable scan, modulo and select scan, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rrbs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire rrbs_pkg::dp_stat_t st,
  output rrbs_pkg::dp_cmd_t       ctl
);
  import rrbs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIS,
    S_REEN,
    S_CHK,
    S_MOD,
    S_SEL,
    S_KEY,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Decode state into datapath commands and the next state
  always_comb begin
    ctl       = '0;
    ctl.scan_mode = SCAN_DIS;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        ctl.accept = in_valid;
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (st.cmd)
          CMD_ADD: begin
            ctl.add   = 1'b1;
            state_nxt = S_DONE;
          end
          CMD_DIS: begin
            ctl.scan_start = 1'b1;
            ctl.scan_mode  = SCAN_DIS;
            state_nxt      = S_DIS;
          end
          CMD_SEL: begin
            if (st.en_zero) begin
              ctl.scan_start = 1'b1;
              ctl.scan_mode  = SCAN_REEN;
              state_nxt      = S_REEN;
            end else begin
              state_nxt = S_CHK;
            end
          end
          default: begin
            ctl.tick  = 1'b1;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_DIS: begin
        if (st.scan_done) state_nxt = S_DONE;
      end
      S_REEN: begin
        if (st.scan_done) state_nxt = S_CHK;
      end
      S_CHK: begin
        if (st.en_zero || st.cnt_zero) begin
          state_nxt = S_DONE;
        end else begin
          ctl.mod_start = 1'b1;
          state_nxt     = S_MOD;
        end
      end
      S_MOD: begin
        ctl.mod_step = 1'b1;
        if (st.mod_done) begin
          ctl.scan_start = 1'b1;
          ctl.scan_mode  = SCAN_SEL;
          state_nxt      = S_SEL;
        end
      end
      S_SEL: begin
        if (st.scan_done) state_nxt = S_KEY;
      end
      S_KEY: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        ctl.load_out = !out_valid_r || out_ready;
        if (ctl.load_out) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[sv/rrbs_dp.sv]
// ----------------------------------------------------------------------------
// rrbs_dp: table, counters and scan engine
// Key and disable-time memories, available flags, the one-entry-per-cycle
// scan pipeline, the subtract-loop modulo and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rrbs_dp #(
  parameter int MAX_ENTRIES = rrbs_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rrbs_pkg::dp_cmd_t ctl,
  output rrbs_pkg::dp_stat_t     st,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [47:0]       in_key,
  input  wire logic              cfg_wen,
  input  wire logic [15:0]       cfg_wdata,
  output logic [1:0]             out_status,
  output logic [3:0]             out_idx,
  output logic [47:0]            out_key,
  output logic [4:0]             out_en
);
  import rrbs_pkg::*;

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  // Request and configuration
  cmd_t         cmd_r;
  logic [47:0]  key_r;
  logic [15:0]  reen_r;
  logic [31:0]  sec_r;

  // Table bookkeeping
  logic [CW-1:0]          cnt_r;
  logic [CW-1:0]          en_r;
  logic [IW-1:0]          round_r;
  logic [MAX_ENTRIES-1:0] avail_r;

  // Per-word outcome
  logic          add_full_r;
  logic [IW-1:0] add_idx_r;
  logic          found_r;
  logic          hit_r;
  logic [IW-1:0] hit_idx_r;
  logic [IW-1:0] want_r;

  // Scan pipeline
  logic          scan_act_r;
  scan_mode_t    mode_r;
  logic [CW-1:0] scan_idx_r;
  logic          cmp_vld_r;
  logic [IW-1:0] cmp_idx_r;

  // Memories
  logic [47:0] key_mem [MAX_ENTRIES];
  logic [31:0] time_mem [MAX_ENTRIES];
  logic [47:0] key_rd_r;
  logic [31:0] time_rd_r;

  // Result registers
  logic [1:0]  out_status_r;
  logic [3:0]  out_idx_r;
  logic [47:0] out_key_r;
  logic [4:0]  out_en_r;

  logic          full;
  logic          issue;
  logic          scan_done;
  logic          mod_done;
  logic          round_wrap;
  logic [31:0]   elapsed;
  logic          cur_avail;
  logic          dis_match;
  logic          reen_hit;
  logic          sel_take;
  logic          sel_skip;
  logic [IW-1:0] key_raddr;
  logic          t_we;
  logic [IW-1:0] t_waddr;
  logic [31:0]   t_wdata;
  status_t       res_status;
  logic [IW-1:0] res_idx;
  logic [31:0]   res_idx_ext;
  logic [31:0]   en_ext;

  assign full       = (cnt_r == MAX_CNT);
  assign issue      = scan_act_r && (scan_idx_r < cnt_r);
  assign scan_done  = scan_act_r && !issue && !cmp_vld_r;
  assign mod_done   = (CW'(want_r) < en_r);
  assign round_wrap = ((CW'(round_r) + CW'(1)) == cnt_r);
  assign elapsed    = sec_r - time_rd_r;
  assign cur_avail  = avail_r[cmp_idx_r];

  // Per-entry decisions in the compare stage
  assign dis_match = cmp_vld_r && (mode_r == SCAN_DIS) && (key_rd_r == key_r);
  assign reen_hit  = cmp_vld_r && (mode_r == SCAN_REEN) && !cur_avail &&
                     (elapsed > {16'h0000, reen_r});
  assign sel_take  = cmp_vld_r && (mode_r == SCAN_SEL) && !hit_r && cur_avail &&
                     (want_r == '0);
  assign sel_skip  = cmp_vld_r && (mode_r == SCAN_SEL) && !hit_r && cur_avail &&
                     (want_r != '0);

  // Key read follows the scan, or parks on the chosen entry once selecting
  assign key_raddr = (mode_r == SCAN_SEL) ? hit_idx_r : scan_idx_r[IW-1:0];

  // Single write port on the time memory
  always_comb begin
    t_we    = 1'b0;
    t_waddr = cnt_r[IW-1:0];
    t_wdata = '0;
    if (ctl.add && !full) begin
      t_we = 1'b1;
    end else if (dis_match) begin
      t_we    = 1'b1;
      t_waddr = cmp_idx_r;
      t_wdata = sec_r;
    end
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reen_r     <= REEN_RESET;
      sec_r      <= '0;
      cnt_r      <= '0;
      en_r       <= '0;
      round_r    <= '0;
      avail_r    <= '0;
      add_full_r <= 1'b0;
      found_r    <= 1'b0;
      hit_r      <= 1'b0;
      scan_act_r <= 1'b0;
      cmp_vld_r  <= 1'b0;
    end else begin
      if (cfg_wen) reen_r <= cfg_wdata;

      // Clear per-word outcome
      if (ctl.accept) begin
        add_full_r <= 1'b0;
        found_r    <= 1'b0;
        hit_r      <= 1'b0;
      end

      // Append an entry, or flag a full table
      if (ctl.add) begin
        if (full) begin
          add_full_r <= 1'b1;
        end else begin
          avail_r[cnt_r[IW-1:0]] <= 1'b1;
          cnt_r <= cnt_r + CW'(1);
          en_r  <= en_r + CW'(1);
        end
      end

      if (ctl.tick) sec_r <= sec_r + 32'd1;

      // Advance the round pointer modulo the entry count
      if (ctl.mod_start) round_r <= round_wrap ? '0 : round_r + IW'(1);

      // Scan issue stage
      if (ctl.scan_start) begin
        scan_act_r <= 1'b1;
        cmp_vld_r  <= 1'b0;
      end else if (scan_act_r) begin
        cmp_vld_r <= issue;
        if (scan_done) scan_act_r <= 1'b0;
      end

      // Scan compare stage
      if (dis_match) begin
        found_r <= 1'b1;
        if (cur_avail) begin
          avail_r[cmp_idx_r] <= 1'b0;
          en_r <= en_r - CW'(1);
        end
      end
      if (reen_hit) begin
        avail_r[cmp_idx_r] <= 1'b1;
        en_r <= en_r + CW'(1);
      end
      if (sel_take) hit_r <= 1'b1;
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r <= cmd_t'(in_cmd);
      key_r <= in_key;
    end
    if (ctl.add) add_idx_r <= cnt_r[IW-1:0];
    if (ctl.scan_start) begin
      scan_idx_r <= '0;
      mode_r     <= ctl.scan_mode;
    end else if (issue) begin
      scan_idx_r <= scan_idx_r + CW'(1);
    end
    cmp_idx_r <= scan_idx_r[IW-1:0];

    // Modulo by repeated subtraction, then count down available entries
    if (ctl.mod_start) begin
      want_r <= round_r;
    end else if (ctl.mod_step && !mod_done) begin
      want_r <= IW'(CW'(want_r) - en_r);
    end else if (sel_skip) begin
      want_r <= want_r - IW'(1);
    end
    if (sel_take) hit_idx_r <= cmp_idx_r;
  end

  // Key and time memories
  always_ff @(posedge clk) begin
    if (ctl.add && !full) key_mem[cnt_r[IW-1:0]] <= key_r;
    if (t_we) time_mem[t_waddr] <= t_wdata;
    key_rd_r  <= key_mem[key_raddr];
    time_rd_r <= time_mem[scan_idx_r[IW-1:0]];
  end

  // Form the result
  always_comb begin
    res_status = ST_OK;
    res_idx    = '0;
    case (cmd_r)
      CMD_ADD: begin
        res_status = add_full_r ? ST_FULL : ST_OK;
        if (!add_full_r) res_idx = add_idx_r;
      end
      CMD_DIS: begin
        res_status = found_r ? ST_OK : ST_NOT_FOUND;
      end
      CMD_SEL: begin
        res_status = hit_r ? ST_OK : ST_NONE;
        if (hit_r) res_idx = hit_idx_r;
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  assign res_idx_ext = 32'(res_idx);
  assign en_ext      = 32'(en_r);

  // Load the output word
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_status_r <= res_status;
      out_idx_r    <= res_idx_ext[3:0];
      out_key_r    <= ((cmd_r == CMD_SEL) && hit_r) ? key_rd_r : 48'h0;
      out_en_r     <= en_ext[4:0];
    end
  end

  assign out_status = out_status_r;
  assign out_idx    = out_idx_r;
  assign out_key    = out_key_r;
  assign out_en     = out_en_r;

  always_comb begin
    st.cmd       = cmd_r;
    st.en_zero   = (en_r == '0);
    st.cnt_zero  = (cnt_r == '0);
    st.scan_done = scan_done;
    st.mod_done  = mod_done;
  end

endmodule

`default_nettype wire

[sv/round_robin_backend_selector.sv]
// ----------------------------------------------------------------------------
// round_robin_backend_selector: backend table with round-robin selection
// Usage: each input word carries a command in in_tuser and an endpoint key in
// in_tdata; every word yields exactly one result word on the out_ channel.
// Commands append a backend, disable all backends with a matching key, pick
// the next available backend in round-robin order (re-enabling long-disabled
// ones when none is left), or advance the seconds counter. cfg_wdata sets the
// re-enable timeout in seconds whenever cfg_wen is high.
// Add and tick need no table scan. Disable scans the stored entries, one entry
// per cycle through the key memory read port. Select runs a re-enable pass
// first when no backend is enabled, then reduces the round pointer modulo the
// enabled count by repeated subtraction and scans the table for the chosen
// entry. One word is in work at a time; the next word is taken in the cycle
// after a result is loaded into the output register.
// Reset clears the table, counters and the timeout (back to 60 seconds);
// the memories need no clearing pass and the block is ready at once.
// A stalled receiver holds the result; the next word is still accepted and
// its result waits in the final state until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_backend_selector #(
  parameter int MAX_ENTRIES = rrbs_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // [47:0] endpoint_key
  input  wire logic [1:0]  in_tuser,   // [1:0] cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [3:0] entry_index, [51:4] selected_key,
                                       // [56:52] enabled_count, rest zero
  output logic [1:0]       out_tuser,  // [1:0] status
  input  wire logic        cfg_wen,
  input  wire logic [15:0] cfg_wdata   // [15:0] reenable_seconds
);
  import rrbs_pkg::*;

  dp_cmd_t     ctl;
  dp_stat_t    st;
  logic [1:0]  res_status;
  logic [3:0]  res_idx;
  logic [47:0] res_key;
  logic [4:0]  res_en;

  rrbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .st        (st),
    .ctl       (ctl)
  );

  rrbs_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .st         (st),
    .in_cmd     (in_tuser),
    .in_key     (in_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .out_status (res_status),
    .out_idx    (res_idx),
    .out_key    (res_key),
    .out_en     (res_en)
  );

  // Pack the result word
  assign out_tdata = {7'h00, res_en, res_key, res_idx};
  assign out_tuser = res_status;

  // One word in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a word is in work");

  // A key is returned only with a successful select
  a_key_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[51:4] != 48'h0) |-> (out_tuser == ST_OK))
    else $error("selected key present with failing status");

  // A full table reports no entry index
  a_full_no_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL) |-> (out_tdata[3:0] == 4'h0))
    else $error("entry index given for a full table");

endmodule

`default_nettype wire
